### rtl/hsc_pkg.sv
// Package for the heading steering controller.
// Holds the controller/datapath command types, state encoding and CORDIC constants.
// No dependencies.
package hsc_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int ZW          = 36;
   localparam int RW          = 50;
   localparam int CNT_W       = 5;
   localparam int TABLE_LEN   = 24;
   localparam int WRAP_STEPS  = 16;
   localparam int IDX_W       = 3;

   localparam logic signed [ZW-1:0] Q30_PI         = 36'sd3373259426;
   localparam logic signed [ZW-1:0] Q30_HALF_PI    = 36'sd1686629713;
   localparam logic signed [RW-1:0] Q30_TWO_PI     = 50'sd6746518852;
   localparam longint               Q30_QUARTER_PI = 64'd843314857;

   localparam logic [IDX_W-1:0] CSR_MODE  = 3'd0;
   localparam logic [IDX_W-1:0] CSR_PROP  = 3'd1;
   localparam logic [IDX_W-1:0] CSR_DERIV = 3'd2;
   localparam logic [IDX_W-1:0] CSR_WBASE = 3'd3;
   localparam logic [IDX_W-1:0] CSR_INVDT = 3'd4;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_VEC_PRE,
      OP_VEC_STEP,
      OP_WRAP_PRE,
      OP_WRAP_STEP,
      OP_WRAP_FIN,
      OP_PD_RATE,
      OP_PD_MUL,
      OP_PD_SUM,
      OP_SIN_PRE,
      OP_ROT_STEP,
      OP_PP_MUL,
      OP_PP_FIN,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [CNT_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic mode;
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_VEC_PRE,
      ST_VEC,
      ST_WRAP_PRE,
      ST_WRAP,
      ST_WRAP_FIN,
      ST_PD_RATE,
      ST_PD_MUL,
      ST_PD_SUM,
      ST_SIN_PRE,
      ST_SIN,
      ST_PP_MUL,
      ST_VEC2,
      ST_PP_FIN,
      ST_DONE
   } state_type;

   function automatic logic [29:0] atan_q30(input logic [CNT_W-1:0] i);
      logic [29:0] v;
      case (i)
         5'd0:    v = 30'd843314857;
         5'd1:    v = 30'd497837829;
         5'd2:    v = 30'd263043837;
         5'd3:    v = 30'd133525159;
         5'd4:    v = 30'd67021687;
         5'd5:    v = 30'd33543516;
         5'd6:    v = 30'd16775851;
         5'd7:    v = 30'd8388437;
         5'd8:    v = 30'd4194283;
         5'd9:    v = 30'd2097149;
         5'd10:   v = 30'd1048576;
         5'd11:   v = 30'd524288;
         5'd12:   v = 30'd262144;
         5'd13:   v = 30'd131072;
         5'd14:   v = 30'd65536;
         5'd15:   v = 30'd32768;
         5'd16:   v = 30'd16384;
         5'd17:   v = 30'd8192;
         5'd18:   v = 30'd4096;
         5'd19:   v = 30'd2048;
         5'd20:   v = 30'd1024;
         5'd21:   v = 30'd512;
         5'd22:   v = 30'd256;
         5'd23:   v = 30'd128;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

### rtl/hsc_ctrl.sv
// Sequencer for the heading steering controller.
// Issues datapath commands and owns the handshakes; depends on hsc_pkg.
module hsc_ctrl #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  hsc_pkg::status_type status,
   output hsc_pkg::cmd_type    cmd
);
   import hsc_pkg::*;

   localparam int NSTEP = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
   localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(NSTEP - 1);
   localparam logic [CNT_W-1:0] WRAP_LAST   = CNT_W'(WRAP_STEPS - 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_load;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_VEC_PRE;
         ST_VEC_PRE:  state_in = ST_VEC;
         ST_VEC:      if (cnt_ff == CORDIC_LAST) state_in = ST_WRAP_PRE;
         ST_WRAP_PRE: state_in = ST_WRAP;
         ST_WRAP:     if (cnt_ff == WRAP_LAST) state_in = ST_WRAP_FIN;
         ST_WRAP_FIN: state_in = status.mode ? ST_SIN_PRE : ST_PD_RATE;
         ST_PD_RATE:  state_in = ST_PD_MUL;
         ST_PD_MUL:   state_in = ST_PD_SUM;
         ST_PD_SUM:   state_in = ST_DONE;
         ST_SIN_PRE:  state_in = ST_SIN;
         ST_SIN:      if (cnt_ff == CORDIC_LAST) state_in = ST_PP_MUL;
         ST_PP_MUL:   state_in = ST_VEC2;
         ST_VEC2:     if (cnt_ff == CORDIC_LAST) state_in = ST_PP_FIN;
         ST_PP_FIN:   state_in = ST_DONE;
         ST_DONE:     if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op   = OP_NONE;
      cmd.idx  = cnt_ff;
      out_load = 1'b0;
      case (state_ff)
         ST_IDLE:     if (req_valid) cmd.op = OP_LOAD;
         ST_VEC_PRE:  cmd.op = OP_VEC_PRE;
         ST_VEC:      cmd.op = OP_VEC_STEP;
         ST_WRAP_PRE: cmd.op = OP_WRAP_PRE;
         ST_WRAP:     cmd.op = OP_WRAP_STEP;
         ST_WRAP_FIN: cmd.op = OP_WRAP_FIN;
         ST_PD_RATE:  cmd.op = OP_PD_RATE;
         ST_PD_MUL:   cmd.op = OP_PD_MUL;
         ST_PD_SUM:   cmd.op = OP_PD_SUM;
         ST_SIN_PRE:  cmd.op = OP_SIN_PRE;
         ST_SIN:      cmd.op = OP_ROT_STEP;
         ST_PP_MUL:   cmd.op = OP_PP_MUL;
         ST_VEC2:     cmd.op = OP_VEC_STEP;
         ST_PP_FIN:   cmd.op = OP_PP_FIN;
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op   = OP_OUT;
               out_load = 1'b1;
            end
         end
         default:     cmd.op = OP_NONE;
      endcase
   end

   always_comb begin
      cnt_in = '0;
      if ((state_ff == ST_VEC || state_ff == ST_WRAP || state_ff == ST_SIN ||
           state_ff == ST_VEC2) && state_in == state_ff) begin
         cnt_in = cnt_ff + 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/hsc_dpath.sv
// Datapath for the heading steering controller: shared CORDIC, angle wrap,
// PD arithmetic, configuration registers and result register; depends on hsc_pkg.
module hsc_dpath (
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [31:0]       req_pos_x,
   input  logic signed [31:0]       req_pos_y,
   input  logic signed [31:0]       req_heading,
   input  logic signed [31:0]       req_goal_x,
   input  logic signed [31:0]       req_goal_y,
   input  logic                     csr_write_en,
   input  logic [hsc_pkg::IDX_W-1:0] csr_index,
   input  logic [30:0]              csr_wdata,
   input  hsc_pkg::cmd_type         cmd,
   output hsc_pkg::status_type      status,
   output logic signed [hsc_pkg::FRAC_BITS:0] rsp_steer_angle
);
   import hsc_pkg::*;

   localparam int SH  = 30 - FRAC_BITS;
   localparam int EW  = FRAC_BITS + 3;
   localparam int RTW = 36;
   localparam longint LIM = (Q30_QUARTER_PI + (64'd1 << (SH - 1))) >> SH;
   localparam logic signed [63:0] LIM_S   = 64'(LIM);
   localparam logic signed [ZW-1:0] ZRND  = ZW'(64'd1 << (SH - 1));
   localparam logic signed [63:0] ACC_RND = 64'(64'd1 << (FRAC_BITS - 1));

   logic              mode_ff;
   logic signed [23:0] prop_ff, deriv_ff;
   logic [30:0]       wbase_ff, invdt_ff;

   logic signed [63:0] x_ff, x_in, y_ff, y_in, dist_ff, dist_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic signed [RW-1:0] r_ff, r_in;
   logic signed [31:0]   th_ff, th_in;
   logic                 same_ff, same_in, neg_ff, neg_in;
   logic signed [EW-1:0] err_ff, err_in, last_ff, last_in;
   logic signed [RTW-1:0] rate_ff, rate_in;
   logic signed [63:0]   p1_ff, p1_in, p2_ff, p2_in;
   logic signed [FRAC_BITS:0] res_ff, res_in, steer_ff, steer_in;

   logic signed [32:0]   dx, dy;
   logic signed [63:0]   xs, ys;
   logic signed [ZW-1:0] at;
   logic signed [RW-1:0] bear, th30, a, m, alpha_w, erw;
   logic signed [EW:0]   diff;
   logic signed [EW+32:0] rprod;
   logic signed [63:0]   acc, q, sv;
   logic signed [65:0]   nprod;
   logic signed [ZW-1:0] zr;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         prop_ff  <= 24'sd6554;
         deriv_ff <= 24'sd0;
         wbase_ff <= 31'd65536;
         invdt_ff <= 31'd655360;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_MODE:  mode_ff  <= csr_wdata[0];
            CSR_PROP:  prop_ff  <= $signed(csr_wdata[23:0]);
            CSR_DERIV: deriv_ff <= $signed(csr_wdata[23:0]);
            CSR_WBASE: wbase_ff <= csr_wdata;
            CSR_INVDT: invdt_ff <= csr_wdata;
            default:   ;
         endcase
      end
   end

   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff; r_in = r_ff; dist_in = dist_ff;
      th_in = th_ff; same_in = same_ff; neg_in = neg_ff; err_in = err_ff;
      rate_in = rate_ff; p1_in = p1_ff; p2_in = p2_ff; res_in = res_ff;
      steer_in = steer_ff;
      dx = $signed({req_goal_x[31], req_goal_x}) - $signed({req_pos_x[31], req_pos_x});
      dy = $signed({req_goal_y[31], req_goal_y}) - $signed({req_pos_y[31], req_pos_y});
      xs = x_ff >>> cmd.idx;
      ys = y_ff >>> cmd.idx;
      at = $signed({6'd0, atan_q30(cmd.idx)});
      bear = same_ff ? '0 : RW'(z_ff);
      th30 = RW'(th_ff) <<< SH;
      a = bear - th30;
      m = Q30_TWO_PI <<< (CNT_W'(WRAP_STEPS - 1) - cmd.idx);
      alpha_w = (r_ff > RW'(Q30_PI)) ? (r_ff - Q30_TWO_PI) : r_ff;
      erw = (alpha_w + RW'(ZRND)) >>> SH;
      diff = (EW + 1)'(err_ff) - (EW + 1)'(last_ff);
      rprod = (EW + 33)'(diff) * (EW + 33)'($signed({1'b0, invdt_ff}));
      acc = p1_ff + p2_ff + ACC_RND;
      q = acc >>> FRAC_BITS;
      sv = neg_ff ? -y_ff : y_ff;
      nprod = 66'($signed({1'b0, wbase_ff})) * 66'($signed(sv[33:0]));
      zr = (z_ff + ZRND) >>> SH;
      case (cmd.op)
         OP_LOAD: begin
            x_in    = $signed({{7{dx[32]}}, dx, 24'd0});
            y_in    = $signed({{7{dy[32]}}, dy, 24'd0});
            same_in = (dx == 33'sd0) && (dy == 33'sd0);
            th_in   = req_heading;
         end
         OP_VEC_PRE: begin
            z_in = '0;
            if (x_ff < 0) begin
               z_in = (y_ff >= 0) ? Q30_PI : -Q30_PI;
               x_in = -x_ff;
               y_in = -y_ff;
            end
         end
         OP_VEC_STEP: begin
            if (y_ff >= 0) begin
               x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + at;
            end else begin
               x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - at;
            end
         end
         OP_WRAP_PRE: begin
            dist_in = x_ff;
            r_in    = (a < 0) ? (a + (Q30_TWO_PI <<< (WRAP_STEPS - 1))) : a;
         end
         OP_WRAP_STEP: begin
            if (r_ff >= m) r_in = r_ff - m;
         end
         OP_WRAP_FIN: begin
            z_in   = ZW'(alpha_w);
            err_in = EW'(erw);
         end
         OP_PD_RATE: begin
            rate_in = RTW'(rprod >>> FRAC_BITS);
         end
         OP_PD_MUL: begin
            p1_in = 64'(prop_ff) * 64'(err_ff);
            p2_in = 64'(deriv_ff) * 64'(rate_ff);
         end
         OP_PD_SUM: begin
            if (q > LIM_S) res_in = (FRAC_BITS + 1)'(LIM_S);
            else if (q < -LIM_S) res_in = (FRAC_BITS + 1)'(-LIM_S);
            else res_in = (FRAC_BITS + 1)'(q);
         end
         OP_SIN_PRE: begin
            x_in   = 64'sd1 <<< 30;
            y_in   = '0;
            neg_in = 1'b0;
            if (z_ff > Q30_HALF_PI) begin
               z_in = z_ff - Q30_PI; neg_in = 1'b1;
            end else if (z_ff < -Q30_HALF_PI) begin
               z_in = z_ff + Q30_PI; neg_in = 1'b1;
            end
         end
         OP_ROT_STEP: begin
            if (z_ff >= 0) begin
               x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - at;
            end else begin
               x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + at;
            end
         end
         OP_PP_MUL: begin
            y_in = 64'(nprod >>> 5);
            x_in = dist_ff;
            z_in = '0;
         end
         OP_PP_FIN: begin
            if (same_ff) res_in = '0;
            else if (64'(zr) > LIM_S) res_in = (FRAC_BITS + 1)'(LIM_S);
            else if (64'(zr) < -LIM_S) res_in = (FRAC_BITS + 1)'(-LIM_S);
            else res_in = (FRAC_BITS + 1)'(zr);
         end
         OP_OUT: steer_in = res_ff;
         default: ;
      endcase
   end

   assign last_in = (cmd.op == OP_PD_MUL) ? err_ff : last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
      end else begin
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; r_ff <= r_in; dist_ff <= dist_in;
      th_ff <= th_in; same_ff <= same_in; neg_ff <= neg_in; err_ff <= err_in;
      rate_ff <= rate_in; p1_ff <= p1_in; p2_ff <= p2_in; res_ff <= res_in;
      steer_ff <= steer_in;
   end

   assign status.mode     = mode_ff;
   assign rsp_steer_angle = steer_ff;

endmodule

### rtl/heading_steering_controller.sv
// Heading steering controller, top level.
// Joins the sequencer hsc_ctrl and the datapath hsc_dpath; depends on hsc_pkg.
// Takes one pose and target transaction at a time and returns one steering angle,
// signed Q1.16, clamped to plus or minus pi/4. CORDIC_STEPS is capped at 24, the
// arctangent table length. The next transaction can be accepted as soon as the
// result is in the output register. The work runs on the single shared
// CORDIC stage, one step per cycle: the bearing and, in pure pursuit, the sine and
// final angle iterations; and on the 16-step modulo-2pi reduction. A finished
// result is held in the output register while the next transaction is accepted;
// a result still stalled there holds the following one back.
module heading_steering_controller #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [31:0]        req_pos_x,
   input  logic signed [31:0]        req_pos_y,
   input  logic signed [31:0]        req_heading,
   input  logic signed [31:0]        req_goal_x,
   input  logic signed [31:0]        req_goal_y,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [hsc_pkg::FRAC_BITS:0] rsp_steer_angle,
   input  logic                      csr_write_en,
   input  logic [hsc_pkg::IDX_W-1:0] csr_index,
   input  logic [30:0]               csr_wdata
);
   import hsc_pkg::*;

   cmd_type    cmd;
   status_type status;

   hsc_ctrl #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   hsc_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_heading     (req_heading),
      .req_goal_x      (req_goal_x),
      .req_goal_y      (req_goal_y),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .status          (status),
      .rsp_steer_angle (rsp_steer_angle)
   );

endmodule

### dv/heading_steering_controller_test.sv
// Self-checking testbench for heading_steering_controller: directed table, then random phases.
// Predicts each steering angle with its own fixed-point CORDIC model; needs rtl/hsc_pkg.sv,
// rtl/hsc_ctrl.sv, rtl/hsc_dpath.sv and rtl/heading_steering_controller.sv.
module heading_steering_controller_test;
   import hsc_pkg::*;

   localparam longint PI_Q30     = 64'sd3373259426;
   localparam longint HALF_PI    = 64'sd1686629713;
   localparam longint TWO_PI     = 64'sd6746518852;
   localparam longint QUARTER_PI = 64'sd843314857;
   localparam int     STEPS      = 16;
   localparam int     LIMIT      = 2000000;
   localparam int     PER_PHASE  = 165;

   typedef struct {
      logic signed [31:0] px, py, th, gx, gy;
      bit                 pinned;
      logic signed [16:0] angle;
   } pose_row;

   typedef struct {
      logic [30:0] mode, prop, deriv, wbase, invdt;
   } gain_set;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [31:0] req_pos_x = 0, req_pos_y = 0, req_heading = 0;
   logic signed [31:0] req_goal_x = 0, req_goal_y = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [16:0] rsp_steer_angle;
   logic csr_write_en = 0;
   logic [IDX_W-1:0] csr_index = CSR_MODE;
   logic [30:0] csr_wdata = 0;

   longint atan_tab [STEPS] = '{843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
      65536, 32768};

   bit     pp_mode;
   longint prop_k, deriv_k, wheel_len, inv_dt, prev_err;

   logic signed [16:0] angle_q [$];
   bit                 pinned_q [$];
   logic signed [16:0] pinned_val_q [$];
   int  failures = 0;
   int  cycles = 0;
   int  angles_seen = 0;
   bit  hold_done = 0;
   int  hold_left = 0;
   int  stall_pct = 0;
   int  stall_left = 0;

   heading_steering_controller dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic longint bearing_q30(longint x, longint y, output longint mag);
      longint z, xs, ys;
      z = 0;
      if (x < 0) begin
         z = (y >= 0) ? PI_Q30 : -PI_Q30;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys; y -= xs; z += atan_tab[i];
         end else begin
            x -= ys; y += xs; z -= atan_tab[i];
         end
      end
      mag = x;
      return z;
   endfunction

   function automatic longint scaled_sine(longint a);
      longint x, y, xs, ys;
      bit neg;
      x = 64'sd1 << 30;
      y = 0;
      neg = 0;
      if (a > HALF_PI) begin
         a -= PI_Q30; neg = 1;
      end else if (a < -HALF_PI) begin
         a += PI_Q30; neg = 1;
      end
      for (int i = 0; i < STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (a >= 0) begin
            x -= ys; y += xs; a -= atan_tab[i];
         end else begin
            x += ys; y -= xs; a += atan_tab[i];
         end
      end
      return neg ? -y : y;
   endfunction

   function automatic longint q30_round(longint a);
      return (a + (64'sd1 << 13)) >>> 14;
   endfunction

   function automatic logic signed [16:0] steer_for(pose_row r);
      longint dx, dy, span_len, bearing, alpha, err, rate, res, lim, num, unused;
      bit same;
      dx = longint'(r.gx) - longint'(r.px);
      dy = longint'(r.gy) - longint'(r.py);
      same = (dx == 0 && dy == 0);
      lim = q30_round(QUARTER_PI);
      bearing = 0;
      span_len = 0;
      if (!same) bearing = bearing_q30(dx <<< 24, dy <<< 24, span_len);
      alpha = bearing - (longint'(r.th) <<< 14);
      alpha = ((alpha % TWO_PI) + TWO_PI) % TWO_PI;
      if (alpha > PI_Q30) alpha -= TWO_PI;
      if (!pp_mode) begin
         err = q30_round(alpha);
         rate = ((err - prev_err) * inv_dt) >>> 16;
         res = (prop_k * err + deriv_k * rate + (64'sd1 << 15)) >>> 16;
         prev_err = err;
      end else if (same) begin
         res = 0;
      end else begin
         num = (wheel_len * scaled_sine(alpha)) >>> 5;
         res = q30_round(bearing_q30(span_len, num, unused));
      end
      if (res > lim) res = lim;
      if (res < -lim) res = -lim;
      return res[16:0];
   endfunction

   always @(posedge clock) begin
      pose_row r;
      if (!reset && req_valid && !req_stall) begin
         r.px = req_pos_x; r.py = req_pos_y; r.th = req_heading;
         r.gx = req_goal_x; r.gy = req_goal_y;
         r.angle = steer_for(r);
         if (pinned_q.pop_front()) r.angle = pinned_val_q[0];
         void'(pinned_val_q.pop_front());
         angle_q.insert(angle_q.size(), r.angle);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         angles_seen++;
         if (angle_q.size() == 0) begin
            $display("%0t steer_angle expected none got %0d", $time, rsp_steer_angle);
            failures++;
         end else if (angle_q[0] !== rsp_steer_angle) begin
            $display("%0t steer_angle expected %0d got %0d", $time, angle_q[0],
                     rsp_steer_angle);
            failures++;
            void'(angle_q.pop_front());
         end else begin
            void'(angle_q.pop_front());
         end
      end
   end

   // receiver: own stall pattern, one long hold-off once the flow is going
   always @(posedge clock) begin
      if (!hold_done && angles_seen >= 300) begin
         hold_done <= 1;
         hold_left <= 600;
         rsp_stall <= 1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1;
      end else begin
         if (stall_left == 0) begin
            stall_left <= $urandom_range(5, 120);
            case ($urandom_range(0, 3))
               0: stall_pct <= 0;
               1: stall_pct <= 30;
               2: stall_pct <= 70;
               default: stall_pct <= 95;
            endcase
         end else begin
            stall_left <= stall_left - 1;
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   int burst_left = 0;

   task automatic offer(pose_row r);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 25);
      end
      burst_left--;
      pinned_q.insert(pinned_q.size(), r.pinned);
      pinned_val_q.insert(pinned_val_q.size(), r.angle);
      req_pos_x <= r.px; req_pos_y <= r.py; req_heading <= r.th;
      req_goal_x <= r.gx; req_goal_y <= r.gy;
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (angle_q.size() != 0 || pinned_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic load_gains(gain_set g);
      csr_write_en <= 1;
      csr_index <= CSR_MODE;  csr_wdata <= g.mode;  @(posedge clock);
      csr_index <= CSR_PROP;  csr_wdata <= g.prop;  @(posedge clock);
      csr_index <= CSR_DERIV; csr_wdata <= g.deriv; @(posedge clock);
      csr_index <= CSR_WBASE; csr_wdata <= g.wbase; @(posedge clock);
      csr_index <= CSR_INVDT; csr_wdata <= g.invdt; @(posedge clock);
      csr_write_en <= 0;
      pp_mode = g.mode[0];
      prop_k = {{40{g.prop[23]}}, g.prop[23:0]};
      deriv_k = {{40{g.deriv[23]}}, g.deriv[23:0]};
      wheel_len = g.wbase;
      inv_dt = g.invdt;
   endtask

   function automatic logic signed [31:0] coord(int span);
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
         default: return $urandom_range(0, 2 * span) - span;
      endcase
   endfunction

   pose_row walk [17] = '{
      '{0, 0, 0, 0, 0, 1, 0},
      '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1, 0},
      '{32'sh80000000, 32'sh80000000, 0, 32'sh80000000, 32'sh80000000, 1, 0},
      '{32'sh80000000, 32'sh80000000, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0},
      '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 32'sh80000000, 32'sh80000000, 0, 0},
      '{32'sh7FFFFFFF, 32'sh80000000, 0, 32'sh80000000, 32'sh7FFFFFFF, 0, 0},
      '{0, 0, 32'sh7FFFFFFF, 0, 0, 0, 0},
      '{0, 0, 32'sh80000000, 0, 0, 0, 0},
      '{0, 0, 205887, 65536, 0, 0, 0},
      '{0, 0, -205887, 65536, 0, 0, 0},
      '{0, 0, 102944, 0, 65536, 0, 0},
      '{0, 0, 0, -65536, 0, 0, 0},
      '{0, 0, 0, -65536, -1, 0, 0},
      '{0, 0, 0, 1, 0, 0, 0},
      '{0, 0, 0, 0, -1, 0, 0},
      '{12345, -54321, 0, 12345, -54321, 1, 0},
      '{0, 0, 411775, 6553600, 3, 0, 0}
   };

   gain_set phases [8] = '{
      '{0, 24'h800000, 24'h7FFFFF, 1, 1},
      '{1, 24'h7FFFFF, 24'h800000, 31'h7FFFFFFF, 31'h7FFFFFFF},
      '{0, 31'h7F010000, 31'h00000400, 0, 0},
      '{1, 6554, 0, 0, 655360},
      '{0, 52000, 3000, 65536, 655360},
      '{1, 6554, 0, 163840, 655360},
      '{31'h7FFFFFFE, 31'h7FFF0000, 31'h40FFFF00, 1000, 31'h7FFFFFFF},
      '{31'h7FFFFFFF, 24'h7FFFFF, 24'hFFFFFF, 31'h00300000, 12345}
   };

   initial begin
      pose_row r;
      gain_set g;
      pp_mode = 0; prop_k = 6554; deriv_k = 0; wheel_len = 65536; inv_dt = 655360;
      prev_err = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (walk[i]) offer(walk[i]);
      drain();
      g = '{1, 6554, 0, 65536, 655360};
      load_gains(g);
      foreach (walk[i]) offer(walk[i]);
      foreach (phases[p]) begin
         drain();
         g = phases[p];
         if (p >= 4) begin
            if (!g.mode[0]) g.deriv = $urandom_range(0, 20000);
            else g.wbase = $urandom_range(1, 400000);
         end
         load_gains(g);
         repeat (PER_PHASE) begin
            r.pinned = 0;
            r.angle = 0;
            r.px = coord(3000000);
            r.py = coord(3000000);
            r.th = coord(600000);
            if ($urandom_range(0, 7) == 0) begin
               r.gx = r.px; r.gy = r.py;
            end else begin
               r.gx = coord(3000000); r.gy = coord(3000000);
            end
            offer(r);
         end
      end
      drain();
      if (failures == 0 && angle_q.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
